### design/q15_pid_duty_regulator_macros.svh
// ----------------------------------------------------------------------------
// q15_pid_duty_regulator_macros.svh
// Assertion shorthands used by the regulator checker file.
// ----------------------------------------------------------------------------
`ifndef Q15_PID_DUTY_REGULATOR_MACROS_SVH
`define Q15_PID_DUTY_REGULATOR_MACROS_SVH

// Check a property on each rising clock edge, masked while reset is asserted
`define Q15PID_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on each rising clock edge, reset included
`define Q15PID_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/q15pid_pkg.sv
// ----------------------------------------------------------------------------
// q15pid_pkg
// Types and constants of the Q15 PID duty regulator.
// ----------------------------------------------------------------------------
`default_nettype none

package q15pid_pkg;

  // Integral accumulator clamp, symmetric around zero
  localparam int unsigned INTEGRAL_LIMIT = 6553600;
  // Fraction bits of the kp/kd gains and of the summed step term
  localparam int unsigned FRACTION_SHIFT = 15;
  // Right shift applied to the ki * integral product
  localparam int unsigned I_GAIN_SHIFT   = 8;

  localparam int unsigned INTEG_W   = 24;
  localparam int unsigned ERR_W     = 13;
  localparam int unsigned DUTY_W    = 16;
  localparam int unsigned SAMPLE_W  = 12;
  localparam int unsigned LOWCNT_W  = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DW    = 16;

  // Request operation codes
  typedef enum logic [0:0] {
    OP_REGULATE = 1'b0,
    OP_CLEAR    = 1'b1
  } op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET        = 3'd0,
    CFG_KP            = 3'd1,
    CFG_KI            = 3'd2,
    CFG_KD            = 3'd3,
    CFG_OUTPUT_MAX    = 3'd4,
    CFG_OUTPUT_MIN    = 3'd5,
    CFG_LOW_THRESHOLD = 3'd6,
    CFG_LOW_LIMIT     = 3'd7
  } cfg_idx_e;

  // Configuration reset values
  localparam logic [11:0] TARGET_RST        = 12'd0;
  localparam logic [14:0] KP_RST            = 15'd2048;
  localparam logic [7:0]  KI_RST            = 8'd1;
  localparam logic [14:0] KD_RST            = 15'd0;
  localparam logic [15:0] OUTPUT_MAX_RST    = 16'd23999;
  localparam logic [15:0] OUTPUT_MIN_RST    = 16'd0;
  localparam logic [11:0] LOW_THRESHOLD_RST = 12'd50;
  localparam logic [3:0]  LOW_LIMIT_RST     = 4'd10;

endpackage

`default_nettype wire

### design/q15_pid_duty_regulator.sv
// ----------------------------------------------------------------------------
// q15_pid_duty_regulator
// Fixed-point PID regulator turning 12-bit voltage samples into PWM duty.
// ----------------------------------------------------------------------------
// One request enters per clock unless a full output register is stalled,
// and its duty result appears in the output register on the next cycle; a
// full output register still accepts a new request in the same cycle it is
// taken. The integral, previous error and output level update directly, so the
// three gain products, step sum, shift and both clamps run between the accepted
// request and those registers. A regulate request with a zero target, or one
// more low sample after low_limit low samples, gives duty 0 with held_off set
// and leaves the state alone. A clear request zeroes the integral and returns
// the stored output level.
// ----------------------------------------------------------------------------
`default_nettype none

module q15_pid_duty_regulator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        operation_i,
  input  wire logic [11:0] measurement_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      duty_o,
  output logic             held_off_o
);
  import q15pid_pkg::*;

  localparam int unsigned P_W   = 29;
  localparam int unsigned I_W   = 33;
  localparam int unsigned D_W   = 30;
  localparam int unsigned SUM_W = 32;

  // configuration registers
  logic [11:0] target_q;
  logic [14:0] kp_q;
  logic [7:0]  ki_q;
  logic [14:0] kd_q;
  logic [15:0] output_max_q;
  logic [15:0] output_min_q;
  logic [11:0] low_threshold_q;
  logic [3:0]  low_limit_q;

  // regulator state
  logic signed [INTEG_W-1:0]  integral_q, integral_d;
  logic signed [ERR_W-1:0]    prev_err_q;
  logic [DUTY_W-1:0]          level_q, level_d;
  logic [LOWCNT_W-1:0]        low_cnt_q, low_cnt_d;

  // result register
  logic              out_valid_q;
  logic [DUTY_W-1:0] duty_q, duty_d;
  logic              held_q, held_d;

  logic in_fire;
  logic is_clear, tgt_zero, is_low, low_ok, do_pid;

  logic signed [ERR_W-1:0]     err;
  logic signed [INTEG_W:0]     acc;
  logic signed [P_W-1:0]       p_term;
  logic signed [I_W-1:0]       i_prod;
  logic signed [I_W-I_GAIN_SHIFT-1:0] i_term;
  logic signed [ERR_W:0]       derr;
  logic signed [D_W-1:0]       d_term;
  logic signed [SUM_W-1:0]     step_sum;
  logic signed [SUM_W-1:0]     step;
  logic signed [SUM_W-1:0]     level_raw;
  logic signed [SUM_W-1:0]     level_hi;
  logic signed [SUM_W-1:0]     level_lo;
  logic signed [SUM_W-1:0]     max_s, min_s;

  // Accept when the result register is empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration write decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q        <= TARGET_RST;
      kp_q            <= KP_RST;
      ki_q            <= KI_RST;
      kd_q            <= KD_RST;
      output_max_q    <= OUTPUT_MAX_RST;
      output_min_q    <= OUTPUT_MIN_RST;
      low_threshold_q <= LOW_THRESHOLD_RST;
      low_limit_q     <= LOW_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TARGET:        target_q        <= cfg_wdata_i[11:0];
        CFG_KP:            kp_q            <= cfg_wdata_i[14:0];
        CFG_KI:            ki_q            <= cfg_wdata_i[7:0];
        CFG_KD:            kd_q            <= cfg_wdata_i[14:0];
        CFG_OUTPUT_MAX:    output_max_q    <= cfg_wdata_i;
        CFG_OUTPUT_MIN:    output_min_q    <= cfg_wdata_i;
        CFG_LOW_THRESHOLD: low_threshold_q <= cfg_wdata_i[11:0];
        CFG_LOW_LIMIT:     low_limit_q     <= cfg_wdata_i[3:0];
      endcase
    end
  end

  // Classify the request
  assign is_clear = (op_e'(operation_i) == OP_CLEAR);
  assign tgt_zero = (target_q == '0);
  assign is_low   = (measurement_i < low_threshold_q);
  assign low_ok   = (low_cnt_q < low_limit_q);
  assign do_pid   = !is_clear && !tgt_zero && (!is_low || low_ok);

  // Error and clamped integral
  always_comb begin
    err = $signed({1'b0, target_q}) - $signed({1'b0, measurement_i});
    acc = (INTEG_W+1)'(integral_q) + (INTEG_W+1)'(err);
    if (acc > $signed((INTEG_W+1)'(INTEGRAL_LIMIT))) begin
      integral_d = INTEG_W'(INTEGRAL_LIMIT);
    end else if (acc < -$signed((INTEG_W+1)'(INTEGRAL_LIMIT))) begin
      integral_d = -$signed(INTEG_W'(INTEGRAL_LIMIT));
    end else begin
      integral_d = acc[INTEG_W-1:0];
    end
  end

  // Gain products, step sum and floor shifts
  always_comb begin
    p_term   = P_W'($signed({1'b0, kp_q})) * P_W'(err);
    i_prod   = I_W'($signed({1'b0, ki_q})) * I_W'(integral_d);
    i_term   = i_prod[I_W-1:I_GAIN_SHIFT];
    derr     = (ERR_W+1)'(err) - (ERR_W+1)'(prev_err_q);
    d_term   = D_W'($signed({1'b0, kd_q})) * D_W'(derr);
    step_sum = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);
    step     = step_sum >>> FRACTION_SHIFT;
  end

  // Add to the stored level, clamp to max and then to min
  always_comb begin
    max_s     = $signed({{(SUM_W-DUTY_W){1'b0}}, output_max_q});
    min_s     = $signed({{(SUM_W-DUTY_W){1'b0}}, output_min_q});
    level_raw = $signed({{(SUM_W-DUTY_W){1'b0}}, level_q}) + step;
    level_hi  = (level_raw > max_s) ? max_s : level_raw;
    level_lo  = (level_hi < min_s) ? min_s : level_hi;
    level_d   = level_lo[DUTY_W-1:0];
    low_cnt_d = is_low ? low_cnt_q + LOWCNT_W'(1) : '0;
  end

  // Select the result fields
  always_comb begin
    if (do_pid) begin
      duty_d = level_d;
      held_d = 1'b0;
    end else if (is_clear) begin
      duty_d = level_q;
      held_d = 1'b0;
    end else begin
      duty_d = '0;
      held_d = 1'b1;
    end
  end

  // Advance the regulator state on an accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
      prev_err_q <= '0;
      level_q    <= '0;
      low_cnt_q  <= '0;
    end else if (in_fire) begin
      if (is_clear) begin
        integral_q <= '0;
      end else if (do_pid) begin
        integral_q <= integral_d;
        prev_err_q <= err;
        level_q    <= level_d;
        low_cnt_q  <= low_cnt_d;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      duty_q <= duty_d;
      held_q <= held_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_q;
  assign held_off_o  = held_q;

endmodule

`default_nettype wire

### design/q15pid_chk.sv
// ----------------------------------------------------------------------------
// q15pid_chk
// Port-level checks of the Q15 PID duty regulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "q15_pid_duty_regulator_macros.svh"

module q15pid_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] duty_o,
  input wire logic        held_off_o
);

  // No result is pending while reset is applied
  `Q15PID_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_o, "result valid in reset")

  // A stalled result stays offered
  `Q15PID_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")

  // Every accepted request shows a result on the next cycle
  `Q15PID_ASSERT(a_in_to_out, clk_i, rst_ni, in_valid_i && in_ready_o |=> out_valid_o, "result missing")

  // An empty result register never blocks the request side
  `Q15PID_ASSERT(a_ready_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o, "stalled while empty")

  // A held-off result always carries zero duty
  `Q15PID_ASSERT(a_held_zero, clk_i, rst_ni, out_valid_o && held_off_o |-> duty_o == 16'd0, "held duty nonzero")

endmodule

bind q15_pid_duty_regulator q15pid_chk u_q15pid_chk (.*);

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Q15 PID duty regulator.
// ----------------------------------------------------------------------------
// A clocked driver feeds sample requests from a queue in random bursts, and a
// clocked monitor takes duty results under a random stall pattern. Each
// accepted request runs through a bit-accurate regulator model kept in the
// bench, and every result is matched field by field against the oldest
// prediction. Registers change only between phases, once the block is empty.
// The stimulus starts with directed corner cases, continues with randomized
// phases and ends with long same-sign runs that build up a large integral of
// each sign.
// ----------------------------------------------------------------------------

module tb_top;
  import q15pid_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned PHASE_ITEMS = 60;
  localparam int unsigned WINDUP_LEN  = 200;
  localparam longint      INTEG_CLAMP = longint'(INTEGRAL_LIMIT);

  typedef struct packed {
    op_e         op;
    logic [11:0] meas;
  } sample_req_t;

  typedef struct packed {
    logic [15:0] duty;
    logic        held_off;
  } duty_res_t;

  // DUT connections; the inputs are known from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b1;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_idx_i     = '0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic        operation_i   = 1'b0;
  logic [11:0] measurement_i = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [15:0] duty_o;
  logic        held_off_o;

  // Register mirror
  logic [11:0] c_target    = TARGET_RST;
  logic [14:0] c_kp        = KP_RST;
  logic [7:0]  c_ki        = KI_RST;
  logic [14:0] c_kd        = KD_RST;
  logic [15:0] c_out_max   = OUTPUT_MAX_RST;
  logic [15:0] c_out_min   = OUTPUT_MIN_RST;
  logic [11:0] c_low_thr   = LOW_THRESHOLD_RST;
  logic [3:0]  c_low_limit = LOW_LIMIT_RST;

  // Regulator state mirror
  longint      integ_sum = 0;
  longint      last_err  = 0;
  logic [15:0] out_level = '0;
  logic [3:0]  low_run   = '0;

  sample_req_t sample_q[$];
  duty_res_t   pending_duty_q[$];
  int unsigned mismatch_cnt = 0;

  // Idle shaping, set per phase by the stimulus
  int unsigned gap_max       = 0;
  int unsigned stall_pct     = 0;
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned burst_left    = 0;
  int unsigned gap_left      = 0;
  int unsigned hold_left     = 0;

  sample_req_t drv_req;
  duty_res_t   drv_res;
  duty_res_t   mon_res;

  q15_pid_duty_regulator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .measurement_i (measurement_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .duty_o        (duty_o),
    .held_off_o    (held_off_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // PID update: integral clamp, floor shifts, output clamps (max then min)
  function automatic logic [15:0] pid_level(input logic [11:0] meas);
    longint err;
    longint acc;
    longint step;
    longint lvl;
    err = longint'(c_target) - longint'(meas);
    acc = integ_sum + err;
    if (acc > INTEG_CLAMP) acc = INTEG_CLAMP;
    if (acc < -INTEG_CLAMP) acc = -INTEG_CLAMP;
    integ_sum = acc;
    step = longint'(c_kp) * err
         + ((longint'(c_ki) * integ_sum) >>> I_GAIN_SHIFT)
         + longint'(c_kd) * (err - last_err);
    last_err = err;
    lvl = longint'(out_level) + (step >>> FRACTION_SHIFT);
    if (lvl > longint'(c_out_max)) lvl = longint'(c_out_max);
    if (lvl < longint'(c_out_min)) lvl = longint'(c_out_min);
    out_level = lvl[15:0];
    return out_level;
  endfunction

  // Duty and hold-off flag for one accepted request
  function automatic duty_res_t compute_duty(input op_e op, input logic [11:0] meas);
    duty_res_t res;
    res.duty     = '0;
    res.held_off = 1'b0;
    if (op == OP_CLEAR) begin
      integ_sum = 0;
      res.duty  = out_level;
    end else if (c_target == '0) begin
      res.held_off = 1'b1;
    end else if (meas < c_low_thr) begin
      if (low_run < c_low_limit) begin
        low_run  = low_run + 4'd1;
        res.duty = pid_level(meas);
      end else begin
        res.held_off = 1'b1;
      end
    end else begin
      low_run  = '0;
      res.duty = pid_level(meas);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic push_sample(input op_e op, input logic [11:0] meas);
    sample_req_t req;
    req.op   = op;
    req.meas = meas;
    sample_q.push_back(req);
  endtask

  // Write one register and update the mirror
  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_TARGET:        c_target    = val[11:0];
      CFG_KP:            c_kp        = val[14:0];
      CFG_KI:            c_ki        = val[7:0];
      CFG_KD:            c_kd        = val[14:0];
      CFG_OUTPUT_MAX:    c_out_max   = val;
      CFG_OUTPUT_MIN:    c_out_min   = val;
      CFG_LOW_THRESHOLD: c_low_thr   = val[11:0];
      CFG_LOW_LIMIT:     c_low_limit = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned tgt, input int unsigned kp,
                            input int unsigned ki, input int unsigned kd,
                            input int unsigned omax, input int unsigned omin,
                            input int unsigned thr, input int unsigned lim);
    write_reg(CFG_TARGET, 16'(tgt));
    write_reg(CFG_KP, 16'(kp));
    write_reg(CFG_KI, 16'(ki));
    write_reg(CFG_KD, 16'(kd));
    write_reg(CFG_OUTPUT_MAX, 16'(omax));
    write_reg(CFG_OUTPUT_MIN, 16'(omin));
    write_reg(CFG_LOW_THRESHOLD, 16'(thr));
    write_reg(CFG_LOW_LIMIT, 16'(lim));
  endtask

  // Hold until every queued request is taken and every result is back
  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid_i || pending_duty_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random value biased toward the ends of its range
  function automatic int unsigned pick_val(input int unsigned hi);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return hi;
      default: return $urandom_range(0, hi) >> $urandom_range(0, 8);
    endcase
  endfunction

  // Driver: advance to the next request once the current one is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        drv_res = compute_duty(op_e'(operation_i), measurement_i);
        pending_duty_q.push_back(drv_res);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (sample_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else begin
          drv_req = sample_q.pop_front();
          in_valid_i    <= 1'b1;
          operation_i   <= drv_req.op;
          measurement_i <= drv_req.meas;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            if (gap_max == 0 || $urandom_range(0, 2) == 0) gap_left = 0;
            else gap_left = $urandom_range(1, gap_max);
          end
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold when requested
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        hold_left = $urandom_range(0, 7);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: match each result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_duty_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result duty=%0d held_off=%0b",
                                  duty_o, held_off_o));
      end else begin
        mon_res = pending_duty_q.pop_front();
        if (duty_o !== mon_res.duty)
          report_mismatch($sformatf("duty got %0d want %0d", duty_o, mon_res.duty));
        if (held_off_o !== mon_res.held_off)
          report_mismatch($sformatf("held_off got %0b want %0b",
                                    held_off_o, mon_res.held_off));
      end
    end
  end

  // Watchdog: end the run after too long without any transfer
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    int unsigned count;
    int unsigned run_len;
    int          level;
    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero target holds every regulate request off
    push_sample(OP_REGULATE, 12'd0);
    push_sample(OP_REGULATE, 12'd4095);
    push_sample(OP_CLEAR, 12'd4095);
    wait_drained();

    // Full gains: negative sums, low run within limit, then low hold-off
    set_config(2000, 32767, 255, 32767, 65535, 0, 50, 2);
    push_sample(OP_REGULATE, 12'd4095);
    push_sample(OP_REGULATE, 12'd2000);
    push_sample(OP_REGULATE, 12'd3000);
    push_sample(OP_REGULATE, 12'd0);
    push_sample(OP_REGULATE, 12'd0);
    push_sample(OP_REGULATE, 12'd49);
    push_sample(OP_REGULATE, 12'd0);
    push_sample(OP_REGULATE, 12'd50);
    push_sample(OP_CLEAR, 12'd0);
    push_sample(OP_REGULATE, 12'd1000);
    push_sample(OP_REGULATE, 12'd4095);
    wait_drained();

    // Min above max, zero low limit: any low sample is held off
    set_config(4095, 0, 0, 0, 100, 500, 4095, 0);
    push_sample(OP_REGULATE, 12'd4095);
    push_sample(OP_REGULATE, 12'd4094);
    push_sample(OP_CLEAR, 12'd1);
    push_sample(OP_REGULATE, 12'd0);
    wait_drained();

    // Unit gains: small negative terms must floor, not truncate
    set_config(1, 1, 1, 1, 65535, 0, 0, 15);
    push_sample(OP_REGULATE, 12'd0);
    push_sample(OP_REGULATE, 12'd1);
    push_sample(OP_REGULATE, 12'd2);
    push_sample(OP_REGULATE, 12'd4095);
    push_sample(OP_REGULATE, 12'd4095);
    wait_drained();

    // Random phases
    for (int ph = 0; ph < 8; ph++) begin
      gap_max   = (ph == 0) ? 0 : $urandom_range(0, 8);
      stall_pct = (ph == 0) ? 0 : $urandom_range(0, 70);
      set_config(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4095),
                 pick_val(32767), pick_val(255), pick_val(32767),
                 ($urandom_range(0, 2) == 0) ? 65535 : $urandom_range(0, 65535),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : pick_val(4000),
                 pick_val(4095), $urandom_range(0, 15));
      if (ph == 2) long_hold_req = 1'b1;
      count = 0;
      while (count < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // track around the setpoint
            run_len = $urandom_range(4, 30);
            repeat (run_len) begin
              level = int'(c_target) + int'($urandom_range(0, 200)) - 100;
              if (level < 0) level = 0;
              if (level > 4095) level = 4095;
              push_sample(OP_REGULATE, 12'(level));
            end
          end
          4, 5: begin
            // run of low samples
            run_len = $urandom_range(1, 20);
            repeat (run_len)
              push_sample(OP_REGULATE, (c_low_thr == '0) ? 12'd0 :
                          12'($urandom_range(0, int'(c_low_thr) - 1)));
          end
          6: begin
            run_len = 1;
            push_sample(OP_REGULATE, ($urandom_range(0, 1) == 0) ? 12'd0 : 12'd4095);
          end
          7, 8: begin
            run_len = $urandom_range(1, 10);
            repeat (run_len) push_sample(OP_REGULATE, 12'($urandom_range(0, 4095)));
          end
          default: begin
            run_len = 1;
            push_sample(OP_CLEAR, 12'($urandom_range(0, 4095)));
          end
        endcase
        count += run_len;
      end
      wait_drained();
    end

    // Integral buildup: grow a large positive integral, clear, then a negative one
    gap_max   = 2;
    stall_pct = 10;
    set_config(4095, pick_val(32767), pick_val(255), pick_val(32767), 65535, 0, 0, 15);
    repeat (WINDUP_LEN) push_sample(OP_REGULATE, 12'($urandom_range(0, 15)));
    push_sample(OP_CLEAR, 12'd0);
    wait_drained();
    write_reg(CFG_TARGET, 16'd1);
    repeat (WINDUP_LEN) push_sample(OP_REGULATE, 12'($urandom_range(4080, 4095)));
    push_sample(OP_CLEAR, 12'd0);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
